FILE: rtl/keypad_calculator_controller_assert.svh
// assertion macros for the keypad calculator controller
`ifndef KEYPAD_CALCULATOR_CONTROLLER_ASSERT_SVH
`define KEYPAD_CALCULATOR_CONTROLLER_ASSERT_SVH
`ifndef ASSERT_OFF
// same-cycle implication, sampled on aclk, off during reset
`define KCC_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);
// next-cycle implication, sampled on aclk, off during reset
`define KCC_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);
`else
`define KCC_ASSERT_IMP(label, ante, cons, msg)
`define KCC_ASSERT_NXT(label, ante, cons, msg)
`endif
`endif

FILE: rtl/kcc_pkg.sv
`default_nettype none
package kcc_pkg;

    // number format and entry limits
    localparam int VAL_W      = 48;
    localparam int FRAC_BITS  = 16;
    localparam int MAX_DIGITS = 9;
    localparam int DIGIT_MAX  = 9;
    localparam int DIG_W      = $clog2(MAX_DIGITS + 1);
    localparam int ENT_W      = VAL_W - FRAC_BITS + 4;
    localparam int DIV_W      = VAL_W + FRAC_BITS;
    localparam int PROD_W     = 2 * VAL_W;
    localparam int CNT_W      = $clog2(DIV_W);
    localparam int OP_W       = 3;

    typedef logic signed [VAL_W-1:0] val_t;
    typedef logic [VAL_W-1:0]        mag_t;

    localparam val_t VAL_MAX = {1'b0, {(VAL_W-1){1'b1}}};
    localparam val_t VAL_MIN = {1'b1, {(VAL_W-1){1'b0}}};
    localparam mag_t MAG_POS = {1'b0, {(VAL_W-1){1'b1}}};
    localparam mag_t MAG_NEG = {1'b1, {(VAL_W-1){1'b0}}};

    // key commands
    localparam logic [1:0] CMD_DIGIT  = 2'd0;
    localparam logic [1:0] CMD_OPER   = 2'd1;
    localparam logic [1:0] CMD_EQUALS = 2'd2;
    localparam logic [1:0] CMD_CLEAR  = 2'd3;

    // operator codes
    localparam logic [OP_W-1:0] OP_ADD  = 3'd0;
    localparam logic [OP_W-1:0] OP_SUB  = 3'd1;
    localparam logic [OP_W-1:0] OP_MUL  = 3'd2;
    localparam logic [OP_W-1:0] OP_DIV  = 3'd3;
    localparam logic [OP_W-1:0] OP_REM  = 3'd4;
    localparam logic [OP_W-1:0] OP_NONE = 3'd7;

    typedef struct packed {
        logic [1:0]      command;
        logic [3:0]      digit_value;
        logic [OP_W-1:0] operator_code;
    } in_item_t;

    typedef struct packed {
        val_t display_value;
        logic overflow_flag;
        logic zero_divide_flag;
    } out_item_t;

    typedef struct packed {
        val_t val;
        logic ovf;
    } sat_t;

    typedef struct packed {
        val_t val;
        logic ovf;
        logic dz;
    } alu_res_t;

    // sequencer strobes into the datapath
    typedef struct packed {
        logic prep;
        logic iter;
        logic fin;
    } alu_ctrl_t;

    function automatic mag_t mag_of(val_t v);
        return v[VAL_W-1] ? mag_t'(-v) : mag_t'(v);
    endfunction

    // sign a magnitude and clamp to the format
    function automatic sat_t sat_signed(logic neg, mag_t mag, logic big);
        sat_t r;
        r.ovf = 1'b0;
        if (!neg) begin
            if (big || mag > MAG_POS) begin
                r.val = VAL_MAX;
                r.ovf = 1'b1;
            end else begin
                r.val = val_t'(mag);
            end
        end else begin
            if (big || mag > MAG_NEG) begin
                r.val = VAL_MIN;
                r.ovf = 1'b1;
            end else begin
                r.val = val_t'(-mag);
            end
        end
        return r;
    endfunction

    // integer entry to fixed point, clamped at the top
    function automatic sat_t entry_value(logic [ENT_W-1:0] n);
        logic [ENT_W+FRAC_BITS-1:0] wide;
        sat_t r;
        wide  = (ENT_W + FRAC_BITS)'(n) << FRAC_BITS;
        r.ovf = |n[ENT_W-1:VAL_W-1-FRAC_BITS];
        r.val = r.ovf ? VAL_MAX : val_t'(wide[VAL_W-1:0]);
        return r;
    endfunction

endpackage
`default_nettype wire

FILE: rtl/kcc_seq.sv
`default_nettype none
module kcc_seq (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire logic                      start,
    input  wire logic [kcc_pkg::OP_W-1:0]  op,
    output kcc_pkg::alu_ctrl_t             ctrl,
    output logic                           done
);
    import kcc_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_PREP = 4'b0010,
        S_ITER = 4'b0100,
        S_FIN  = 4'b1000
    } seq_state_t;

    seq_state_t        state_reg, state_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              done_reg;

    // step count per operation
    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        case (state_reg)
            S_IDLE: begin
                if (start) begin
                    state_next = S_PREP;
                    case (op)
                        OP_MUL:         cnt_next = CNT_W'(VAL_W - 1);
                        OP_DIV, OP_REM: cnt_next = CNT_W'(DIV_W - 1);
                        default:        cnt_next = '0;
                    endcase
                end
            end
            S_PREP: state_next = S_ITER;
            S_ITER: begin
                if (cnt_reg == '0) begin
                    state_next = S_FIN;
                end else begin
                    cnt_next = cnt_reg - 1'b1;
                end
            end
            S_FIN:   state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
            done_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            done_reg  <= (state_reg == S_FIN);
        end
    end

    // strobes to the shared unit
    assign ctrl.prep = (state_reg == S_PREP);
    assign ctrl.iter = (state_reg == S_ITER);
    assign ctrl.fin  = (state_reg == S_FIN);
    assign done      = done_reg;

endmodule
`default_nettype wire

FILE: rtl/kcc_alu.sv
`default_nettype none
module kcc_alu (
    input  wire logic                      aclk,
    input  wire logic                      start,
    input  wire logic [kcc_pkg::OP_W-1:0]  op,
    input  wire kcc_pkg::val_t             a,
    input  wire kcc_pkg::val_t             b,
    input  wire kcc_pkg::alu_ctrl_t        ctrl,
    output kcc_pkg::alu_res_t              res
);
    import kcc_pkg::*;

    localparam int AW = VAL_W + 2;

    logic [OP_W-1:0]   op_reg;
    val_t              a_reg, b_reg;
    mag_t              opd_reg, hi_reg, lo_reg;
    logic [DIV_W-1:0]  dvd_reg;
    logic              big_reg, neg_reg, dz_reg;
    alu_res_t          res_reg, fin_res;

    mag_t              ua, ub;
    logic [VAL_W:0]    rem_sh;
    logic [AW-1:0]     add_x, add_y, sum;
    logic              add_sub, ge;
    logic [PROD_W-1:0] prod_sh;
    mag_t              rem_fx;
    sat_t              sat_mul, sat_div;

    assign ua     = mag_of(a_reg);
    assign ub     = mag_of(b_reg);
    assign rem_sh = {hi_reg, dvd_reg[DIV_W-1]};

    // the one shared adder: sum, partial product or trial subtract
    always_comb begin
        add_x   = '0;
        add_y   = '0;
        add_sub = 1'b0;
        case (op_reg)
            OP_ADD, OP_SUB: begin
                add_x   = {{2{a_reg[VAL_W-1]}}, a_reg};
                add_y   = {{2{b_reg[VAL_W-1]}}, b_reg};
                add_sub = (op_reg == OP_SUB);
            end
            OP_MUL: begin
                add_x = {2'b00, hi_reg};
                add_y = lo_reg[0] ? {2'b00, opd_reg} : '0;
            end
            OP_DIV, OP_REM: begin
                add_x   = {1'b0, rem_sh};
                add_y   = {2'b00, opd_reg};
                add_sub = 1'b1;
            end
            default: begin
                add_x = '0;
            end
        endcase
        sum = add_x + (add_sub ? ~add_y : add_y) + AW'(add_sub);
    end

    assign ge = ~sum[AW-1];

    // operand set-up, one step per cycle, result capture
    always_ff @(posedge aclk) begin
        if (start) begin
            op_reg <= op;
            a_reg  <= a;
            b_reg  <= b;
        end
        if (ctrl.prep) begin
            hi_reg  <= '0;
            big_reg <= 1'b0;
            case (op_reg)
                OP_MUL: begin
                    lo_reg  <= ub;
                    opd_reg <= ua;
                    dz_reg  <= 1'b0;
                    neg_reg <= a_reg[VAL_W-1] ^ b_reg[VAL_W-1];
                end
                OP_DIV: begin
                    lo_reg  <= '0;
                    dvd_reg <= DIV_W'(ua) << FRAC_BITS;
                    opd_reg <= ub;
                    dz_reg  <= (ub == '0);
                    neg_reg <= a_reg[VAL_W-1] ^ b_reg[VAL_W-1];
                end
                OP_REM: begin
                    lo_reg  <= '0;
                    dvd_reg <= DIV_W'(ua >> FRAC_BITS);
                    opd_reg <= ub >> FRAC_BITS;
                    dz_reg  <= ((ub >> FRAC_BITS) == '0);
                    neg_reg <= a_reg[VAL_W-1];
                end
                default: begin
                    lo_reg  <= '0;
                    opd_reg <= '0;
                    dz_reg  <= 1'b0;
                    neg_reg <= a_reg[VAL_W-1] ^ b_reg[VAL_W-1];
                end
            endcase
        end
        if (ctrl.iter) begin
            case (op_reg)
                OP_ADD, OP_SUB: begin
                    hi_reg  <= sum[VAL_W-1:0];
                    big_reg <= sum[VAL_W];
                end
                OP_MUL: begin
                    hi_reg <= sum[VAL_W:1];
                    lo_reg <= {sum[0], lo_reg[VAL_W-1:1]};
                end
                OP_DIV, OP_REM: begin
                    hi_reg  <= ge ? sum[VAL_W-1:0] : rem_sh[VAL_W-1:0];
                    lo_reg  <= {lo_reg[VAL_W-2:0], ge};
                    big_reg <= big_reg | lo_reg[VAL_W-1];
                    dvd_reg <= dvd_reg << 1;
                end
                default: begin
                    big_reg <= big_reg;
                end
            endcase
        end
        if (ctrl.fin) begin
            res_reg <= fin_res;
        end
    end

    assign prod_sh = {hi_reg, lo_reg} >> FRAC_BITS;
    assign rem_fx  = mag_t'(hi_reg << FRAC_BITS);
    assign sat_mul = sat_signed(neg_reg, prod_sh[VAL_W-1:0], |prod_sh[PROD_W-1:VAL_W]);
    assign sat_div = sat_signed(neg_reg, lo_reg, big_reg);

    // sign, clamp and special cases
    always_comb begin
        fin_res.val = a_reg;
        fin_res.ovf = 1'b0;
        fin_res.dz  = 1'b0;
        case (op_reg)
            OP_ADD, OP_SUB: begin
                if (big_reg != hi_reg[VAL_W-1]) begin
                    fin_res.val = big_reg ? VAL_MIN : VAL_MAX;
                    fin_res.ovf = 1'b1;
                end else begin
                    fin_res.val = val_t'(hi_reg);
                end
            end
            OP_MUL: begin
                fin_res.val = sat_mul.val;
                fin_res.ovf = sat_mul.ovf;
            end
            OP_DIV: begin
                if (dz_reg) begin
                    fin_res.dz = 1'b1;
                    if (a_reg[VAL_W-1]) begin
                        fin_res.val = VAL_MIN;
                    end else if (a_reg != '0) begin
                        fin_res.val = VAL_MAX;
                    end else begin
                        fin_res.val = '0;
                    end
                end else begin
                    fin_res.val = sat_div.val;
                    fin_res.ovf = sat_div.ovf;
                end
            end
            OP_REM: begin
                if (dz_reg) begin
                    fin_res.dz  = 1'b1;
                    fin_res.val = '0;
                end else begin
                    fin_res.val = neg_reg ? val_t'(-rem_fx) : val_t'(rem_fx);
                end
            end
            default: begin
                fin_res.val = a_reg;
            end
        endcase
    end

    assign res = res_reg;

endmodule
`default_nettype wire

FILE: rtl/keypad_calculator_controller.sv
`default_nettype none
`include "keypad_calculator_controller_assert.svh"
// Five-function keypad calculator: one key item in, one display item out. Digit,
// clear, equals with nothing pending and operator keys that only load the
// accumulator give their result in the cycle after acceptance. A key that evaluates
// runs on one shared 50-bit adder stepped by a small sequencer: one step for add
// and subtract, one shift-add per cycle for multiply, and one restoring quotient bit
// per cycle for divide and remainder over a 64-bit (VAL_W + FRAC_BITS) dividend.
// One key is in flight at a time; s_ready is low while it works and while a result
// waits in the output register. Values are signed Q31.16.
module keypad_calculator_controller (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire kcc_pkg::in_item_t  s_item,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output kcc_pkg::out_item_t      m_item
);
    import kcc_pkg::*;

    typedef enum logic [2:0] {
        T_IDLE = 3'b001,
        T_CALC = 3'b010,
        T_POST = 3'b100
    } top_state_t;

    top_state_t        state_reg, state_next;
    val_t              shown_reg, shown_next;
    val_t              acc_reg, acc_next;
    logic [OP_W-1:0]   pend_reg, pend_next;
    logic              fresh_reg, fresh_next;
    logic [DIG_W-1:0]  digits_reg, digits_next;
    logic              m_valid_reg, m_valid_next;
    out_item_t         m_item_reg, m_item_next;
    in_item_t          key_reg, key_next;

    logic              accept, slot_free, needs_alu, alu_start, alu_done, key_ovf;
    alu_ctrl_t         alu_ctrl;
    alu_res_t          alu_res;
    logic [ENT_W-1:0]  cur_int, n_append;
    sat_t              ent_fresh, ent_app;

    assign slot_free = !m_valid_reg || m_ready;
    assign s_ready   = (state_reg == T_IDLE) && slot_free;
    assign accept    = s_valid && s_ready;

    // keys that need the shared unit
    assign needs_alu =
        ((s_item.command == CMD_OPER) && (s_item.operator_code <= OP_REM) &&
         (pend_reg != OP_NONE) && !fresh_reg) ||
        ((s_item.command == CMD_EQUALS) && (pend_reg != OP_NONE));
    assign alu_start = accept && needs_alu;

    // decimal entry: times ten plus digit
    assign cur_int   = ENT_W'(shown_reg[VAL_W-1:FRAC_BITS]);
    assign n_append  = (cur_int << 3) + (cur_int << 1) + ENT_W'(s_item.digit_value);
    assign ent_fresh = entry_value(ENT_W'(s_item.digit_value));
    assign ent_app   = entry_value(n_append);

    // key handling and result hand-off
    always_comb begin
        state_next   = state_reg;
        shown_next   = shown_reg;
        acc_next     = acc_reg;
        pend_next    = pend_reg;
        fresh_next   = fresh_reg;
        digits_next  = digits_reg;
        key_next     = key_reg;
        m_item_next  = m_item_reg;
        m_valid_next = m_valid_reg && !m_ready;
        key_ovf      = 1'b0;
        case (state_reg)
            T_IDLE: begin
                if (accept && needs_alu) begin
                    key_next   = s_item;
                    state_next = T_CALC;
                end else if (accept) begin
                    case (s_item.command)
                        CMD_DIGIT: begin
                            if (s_item.digit_value <= 4'(DIGIT_MAX)) begin
                                if (fresh_reg) begin
                                    shown_next = ent_fresh.val;
                                    key_ovf    = ent_fresh.ovf;
                                    if (s_item.digit_value != '0) begin
                                        fresh_next  = 1'b0;
                                        digits_next = DIG_W'(1);
                                    end else begin
                                        digits_next = '0;
                                    end
                                end else if (digits_reg < DIG_W'(MAX_DIGITS)) begin
                                    shown_next  = ent_app.val;
                                    key_ovf     = ent_app.ovf;
                                    digits_next = digits_reg + 1'b1;
                                end
                            end
                        end
                        CMD_OPER: begin
                            if (s_item.operator_code <= OP_REM) begin
                                acc_next    = shown_reg;
                                pend_next   = s_item.operator_code;
                                fresh_next  = 1'b1;
                                digits_next = '0;
                            end
                        end
                        CMD_EQUALS: begin
                            shown_next  = acc_reg;
                            pend_next   = OP_NONE;
                            fresh_next  = 1'b1;
                            digits_next = '0;
                        end
                        CMD_CLEAR: begin
                            shown_next  = '0;
                            acc_next    = '0;
                            pend_next   = OP_NONE;
                            fresh_next  = 1'b1;
                            digits_next = '0;
                        end
                        default: begin
                            shown_next = shown_reg;
                        end
                    endcase
                    m_item_next.display_value    = shown_next;
                    m_item_next.overflow_flag    = key_ovf;
                    m_item_next.zero_divide_flag = 1'b0;
                    m_valid_next                 = 1'b1;
                end
            end
            T_CALC: begin
                if (alu_done) begin
                    state_next = T_POST;
                end
            end
            T_POST: begin
                if (slot_free) begin
                    acc_next    = alu_res.val;
                    shown_next  = alu_res.val;
                    pend_next   = (key_reg.command == CMD_OPER) ? key_reg.operator_code
                                                                : OP_NONE;
                    fresh_next  = 1'b1;
                    digits_next = '0;
                    m_item_next.display_value    = alu_res.val;
                    m_item_next.overflow_flag    = alu_res.ovf;
                    m_item_next.zero_divide_flag = alu_res.dz;
                    m_valid_next = 1'b1;
                    state_next   = T_IDLE;
                end
            end
            default: state_next = T_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= T_IDLE;
            shown_reg   <= '0;
            acc_reg     <= '0;
            pend_reg    <= OP_NONE;
            fresh_reg   <= 1'b1;
            digits_reg  <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            shown_reg   <= shown_next;
            acc_reg     <= acc_next;
            pend_reg    <= pend_next;
            fresh_reg   <= fresh_next;
            digits_reg  <= digits_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        m_item_reg <= m_item_next;
        key_reg    <= key_next;
    end

    assign m_valid = m_valid_reg;
    assign m_item  = m_item_reg;

    // sequencer and shared arithmetic unit
    kcc_seq u_seq (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (alu_start),
        .op      (pend_reg),
        .ctrl    (alu_ctrl),
        .done    (alu_done)
    );

    kcc_alu u_alu (
        .aclk  (aclk),
        .start (alu_start),
        .op    (pend_reg),
        .a     (acc_reg),
        .b     (shown_reg),
        .ctrl  (alu_ctrl),
        .res   (alu_res)
    );

    // checks
    `KCC_ASSERT_IMP(no_ready_while_busy, state_reg != T_IDLE, !s_ready, "ready while busy")
    `KCC_ASSERT_IMP(done_only_in_calc, alu_done, state_reg == T_CALC, "stray unit done")
    `KCC_ASSERT_IMP(fresh_has_no_digits, fresh_reg, digits_reg == '0, "digits on fresh entry")
    `KCC_ASSERT_NXT(clear_shows_zero, accept && s_item.command == CMD_CLEAR, m_valid && m_item.display_value == '0 && !m_item.overflow_flag && !m_item.zero_divide_flag, "clear not zero")

endmodule
`default_nettype wire
